FILE: hdl/csrspmv_pkg.sv
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared widths, item codes and queue entry type for the compressed-row
// sparse matrix times dense vector block.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int ADDR_W      = $clog2(MAX_COLUMNS);

	localparam int KIND_W      = 2;
	localparam int INDEX_W     = 12;
	localparam int VALUE_W     = 32;
	localparam int ACC_W       = 64;
	localparam int ROW_W       = 16;
	localparam int FRAC_W      = 16;
	localparam int QHI_W       = ACC_W - FRAC_W - VALUE_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_NONZERO = 2'd1,
		KIND_EMPTY   = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] product;
		logic                    close;
	} qentry_t;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} qstatus_t;

endpackage

FILE: hdl/csrspmv_if.sv
// ----------------------------------------------------------------------------
// csrspmv item and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface csrspmv_item_if;
	logic                                   valid;
	logic                                   ready;
	logic [csrspmv_pkg::KIND_W-1:0]         kind;
	logic [csrspmv_pkg::INDEX_W-1:0]        index;
	logic signed [csrspmv_pkg::VALUE_W-1:0] value;
	logic                                   end_of_row;

	modport source (output valid, kind, index, value, end_of_row, input ready);
	modport sink (input valid, kind, index, value, end_of_row, output ready);
endinterface

interface csrspmv_result_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [csrspmv_pkg::VALUE_W-1:0] row_value;
	logic [csrspmv_pkg::ROW_W-1:0]          row_number;
	logic                                   last_row;
	logic                                   overflow;

	modport source (output valid, row_value, row_number, last_row, overflow, input ready);
	modport sink (input valid, row_value, row_number, last_row, overflow, output ready);
endinterface

FILE: hdl/csrspmv_front.sv
// ----------------------------------------------------------------------------
// csrspmv_front
// Accepts items, holds the vector store, reads the column element and
// forms the product; pushes nonzero and empty-row work into the queue.
// ----------------------------------------------------------------------------
module csrspmv_front (
	input  logic                       clk,
	input  logic                       arst_n,
	csrspmv_item_if.sink               item,
	input  csrspmv_pkg::qstatus_t      status,
	output logic                       push,
	output csrspmv_pkg::qentry_t       entry
);

	logic [csrspmv_pkg::VALUE_W-1:0] mem [csrspmv_pkg::MAX_COLUMNS];

	logic                                   accept;
	logic                                   is_load;
	logic                                   is_work;
	logic                                   is_empty;
	logic                                   in_range;
	logic [csrspmv_pkg::ADDR_W-1:0]         addr;
	logic [csrspmv_pkg::CNT_W:0]            pending;

	logic                                   valid_s1;
	logic signed [csrspmv_pkg::VALUE_W-1:0] value_s1;
	logic signed [csrspmv_pkg::VALUE_W-1:0] rdata_s1;
	logic                                   close_s1;
	logic                                   zero_s1;
	logic signed [csrspmv_pkg::ACC_W-1:0]   product;

	logic                                   valid_s2;
	csrspmv_pkg::qentry_t                   entry_s2;

	always_comb begin
		is_load  = 1'b0;
		is_work  = 1'b0;
		is_empty = 1'b0;
		unique case (csrspmv_pkg::kind_t'(item.kind))
			csrspmv_pkg::KIND_LOAD: begin
				is_load = 1'b1;
			end
			csrspmv_pkg::KIND_NONZERO: begin
				is_work = 1'b1;
			end
			csrspmv_pkg::KIND_EMPTY: begin
				is_work  = 1'b1;
				is_empty = 1'b1;
			end
			default: begin
				is_load = 1'b0;
			end
		endcase
	end

	assign in_range = 32'(item.index) < csrspmv_pkg::MAX_COLUMNS;
	assign addr     = csrspmv_pkg::ADDR_W'(item.index);

	// hold off new items unless every item in flight has a queue slot
	assign pending = (csrspmv_pkg::CNT_W + 1)'(status.count)
		+ (csrspmv_pkg::CNT_W + 1)'(valid_s1) + (csrspmv_pkg::CNT_W + 1)'(valid_s2);
	assign item.ready = pending < (csrspmv_pkg::CNT_W + 1)'(csrspmv_pkg::QUEUE_DEPTH);
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk) begin
		if (accept && is_load && in_range) begin
			mem[addr] <= item.value;
		end
		rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= item.value;
			close_s1 <= is_empty || item.end_of_row;
			zero_s1  <= is_empty || !in_range;
		end
	end

	assign product = value_s1 * rdata_s1;

	always_ff @(posedge clk) begin
		entry_s2.product <= zero_s1 ? '0 : product;
		entry_s2.close   <= close_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept && is_work;
			valid_s2 <= valid_s1;
		end
	end

	assign push  = valid_s2;
	assign entry = entry_s2;

endmodule

FILE: hdl/csrspmv_fifo.sv
// ----------------------------------------------------------------------------
// csrspmv_fifo
// Short queue of products between the front and the accumulator.
// ----------------------------------------------------------------------------
module csrspmv_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  csrspmv_pkg::qentry_t  wr_entry,
	input  logic                  pop,
	output csrspmv_pkg::qentry_t  head,
	output csrspmv_pkg::qstatus_t status
);

	csrspmv_pkg::qentry_t             slot_q [csrspmv_pkg::QUEUE_DEPTH];
	logic [csrspmv_pkg::PTR_W-1:0]    wptr_q;
	logic [csrspmv_pkg::PTR_W-1:0]    rptr_q;
	logic [csrspmv_pkg::CNT_W-1:0]    count_q;

	function automatic logic [csrspmv_pkg::PTR_W-1:0] next_ptr(
		input logic [csrspmv_pkg::PTR_W-1:0] p
	);
		if (p == csrspmv_pkg::PTR_W'(csrspmv_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = slot_q[rptr_q];
	assign status.count = count_q;
	assign status.empty = count_q == '0;

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < csrspmv_pkg::CNT_W'(csrspmv_pkg::QUEUE_DEPTH)))
		else $error("queue push while full");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree with empty count");

endmodule

FILE: hdl/csrspmv_back.sv
// ----------------------------------------------------------------------------
// csrspmv_back
// Row accumulator with saturation, row counter and result register.
// ----------------------------------------------------------------------------
module csrspmv_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csrspmv_pkg::ROW_W-1:0]  cfg_data,
	input  csrspmv_pkg::qstatus_t          status,
	input  csrspmv_pkg::qentry_t           head,
	output logic                           pop,
	csrspmv_result_if.source               result
);

	logic [csrspmv_pkg::ROW_W-1:0]        row_count_q;
	logic signed [csrspmv_pkg::ACC_W-1:0] acc_q;
	logic                                 sat_q;
	logic [csrspmv_pkg::ROW_W-1:0]        row_q;

	logic                                 out_valid_q;
	logic signed [csrspmv_pkg::VALUE_W-1:0] out_value_q;
	logic [csrspmv_pkg::ROW_W-1:0]        out_row_q;
	logic                                 out_last_q;
	logic                                 out_ovf_q;

	logic signed [csrspmv_pkg::ACC_W-1:0] sum;
	logic                                 add_ovf;
	logic signed [csrspmv_pkg::ACC_W-1:0] acc_next;
	logic                                 sat_next;
	logic [csrspmv_pkg::QHI_W-1:0]        qhi;
	logic                                 q_fits;
	logic signed [csrspmv_pkg::VALUE_W-1:0] q_value;
	logic                                 last;

	assign sum     = acc_q + head.product;
	assign add_ovf = (acc_q[csrspmv_pkg::ACC_W-1] == head.product[csrspmv_pkg::ACC_W-1])
		&& (sum[csrspmv_pkg::ACC_W-1] != acc_q[csrspmv_pkg::ACC_W-1]);

	always_comb begin
		if (!add_ovf) begin
			acc_next = sum;
		end else if (head.product[csrspmv_pkg::ACC_W-1]) begin
			acc_next = {1'b1, {(csrspmv_pkg::ACC_W - 1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(csrspmv_pkg::ACC_W - 1){1'b1}}};
		end
	end
	assign sat_next = sat_q || add_ovf;

	// drop the low fraction bits (floor), then clamp to the result width
	assign qhi    = acc_next[csrspmv_pkg::ACC_W-1 -: csrspmv_pkg::QHI_W];
	assign q_fits = (qhi == '0) || (qhi == '1);

	always_comb begin
		if (q_fits) begin
			q_value = acc_next[csrspmv_pkg::FRAC_W +: csrspmv_pkg::VALUE_W];
		end else if (acc_next[csrspmv_pkg::ACC_W-1]) begin
			q_value = {1'b1, {(csrspmv_pkg::VALUE_W - 1){1'b0}}};
		end else begin
			q_value = {1'b0, {(csrspmv_pkg::VALUE_W - 1){1'b1}}};
		end
	end

	assign last = ({1'b0, row_q} + (csrspmv_pkg::ROW_W + 1)'(1)) >= {1'b0, row_count_q};

	assign pop = !status.empty && (!head.close || !out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= csrspmv_pkg::ROW_W'(1);
			acc_q       <= '0;
			sat_q       <= 1'b0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				row_count_q <= cfg_data;
			end
			if (pop && head.close) begin
				acc_q       <= '0;
				sat_q       <= 1'b0;
				row_q       <= last ? '0 : row_q + 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					acc_q <= acc_next;
					sat_q <= sat_next;
				end
				if (result.ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.close) begin
			out_value_q <= q_value;
			out_row_q   <= row_q;
			out_last_q  <= last;
			out_ovf_q   <= sat_next || !q_fits;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.row_value  = out_value_q;
	assign result.row_number = out_row_q;
	assign result.last_row   = out_last_q;
	assign result.overflow   = out_ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.close && last) |=> (row_q == '0))
		else $error("row counter did not return to zero after last row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.close) |=> (acc_q == '0 && !sat_q && out_valid_q))
		else $error("row close did not clear accumulator or raise result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !(pop && head.close))
		else $error("closing row would overwrite a pending result");

endmodule

FILE: hdl/csr_sparse_matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Compressed-row sparse matrix times dense vector in signed Q16.16.
// Path from item transfer to result valid: store read at the transfer, then
// multiply, queue write, and accumulate into the result register.
// Throughput: one item per cycle while the queue has room and results are taken,
// set by the single-port vector store read and the accumulator add loop.
// Reset clears the accumulator, row counter, queue and row_count (to 1);
// the vector store holds no reset value and is undefined until written.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [csrspmv_pkg::ROW_W-1:0] cfg_data,
	csrspmv_item_if.sink                  item,
	csrspmv_result_if.source              result
);

	logic                  push;
	logic                  pop;
	csrspmv_pkg::qentry_t  wr_entry;
	csrspmv_pkg::qentry_t  head;
	csrspmv_pkg::qstatus_t status;

	csrspmv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.status (status),
		.push   (push),
		.entry  (wr_entry)
	);

	csrspmv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	csrspmv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.status   (status),
		.head     (head),
		.pop      (pop),
		.result   (result)
	);

endmodule
